/* design/sedh_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sedh_pkg;

   // Field and accumulator widths.
   localparam int PIX_W = 8;
   localparam int ACC_W = 18;
   localparam int WGT_W = 11;
   localparam int DEFAULT_MAX_WIDTH = 1024;

   // Fixed-point levels in Q10.8.
   localparam logic signed [ACC_W:0] THRESH_Q8 = 19'sd32512;
   localparam logic signed [ACC_W:0] FULL_Q8 = 19'sd65280;
   localparam logic signed [ACC_W:0] ACC_MAX = 19'sd131071;
   localparam logic signed [ACC_W:0] ACC_MIN = -19'sd131072;

   // Register indexes.
   localparam logic [1:0] REG_IMAGE_WIDTH = 2'd0;
   localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
   localparam logic [1:0] REG_KERNEL_SELECT = 2'd2;
   localparam logic [1:0] REG_INVERT_MODE = 2'd3;

   // Kernel codes; the unused code behaves as Floyd-Steinberg.
   localparam logic [1:0] KERNEL_FS = 2'd0;
   localparam logic [1:0] KERNEL_JJN = 2'd1;
   localparam logic [1:0] KERNEL_STUCKI = 2'd2;

   // Row store roles relative to the current row.
   localparam logic [1:0] ROLE_CUR = 2'd0;
   localparam logic [1:0] ROLE_NXT = 2'd1;
   localparam logic [1:0] ROLE_FAR = 2'd2;

   typedef struct packed {
      logic [10:0] image_width;
      logic [15:0] image_height;
      logic [1:0] kernel_select;
      logic invert_mode;
   } cfg_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_LOAD,
      ST_RUN,
      ST_FLUSH
   } seq_state_type;

   // Q.12 weights by row offset and column offset (-2..2) along the scan.
   localparam logic [WGT_W-1:0] FS_W [3][5] = '{
      '{11'd0, 11'd0, 11'd0, 11'd1792, 11'd0},
      '{11'd0, 11'd768, 11'd1280, 11'd256, 11'd0},
      '{11'd0, 11'd0, 11'd0, 11'd0, 11'd0}};
   localparam logic [WGT_W-1:0] JJN_W [3][5] = '{
      '{11'd0, 11'd0, 11'd0, 11'd597, 11'd427},
      '{11'd256, 11'd427, 11'd597, 11'd427, 11'd256},
      '{11'd85, 11'd256, 11'd427, 11'd256, 11'd85}};
   localparam logic [WGT_W-1:0] STK_W [3][5] = '{
      '{11'd0, 11'd0, 11'd0, 11'd780, 11'd390},
      '{11'd195, 11'd390, 11'd780, 11'd390, 11'd195},
      '{11'd98, 11'd195, 11'd390, 11'd195, 11'd98}};

   function automatic logic [WGT_W-1:0] kernel_weight(input logic [1:0] k, input int dy,
                                                      input int ix);
      logic [WGT_W-1:0] w;
      case (k)
         KERNEL_JJN: w = JJN_W[dy][ix];
         KERNEL_STUCKI: w = STK_W[dy][ix];
         default: w = FS_W[dy][ix];
      endcase
      return w;
   endfunction

   // Error times weight, rounded from Q.20 to Q.8 with halves up.
   function automatic logic signed [ACC_W-1:0] contrib(input logic signed [ACC_W-1:0] e,
                                                       input logic [WGT_W-1:0] w);
      logic signed [29:0] p;
      p = 30'(e) * $signed(30'(w));
      p = p + 30'sd2048;
      return ACC_W'(p >>> 12);
   endfunction

   // Saturating add of two accumulator values.
   function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
                                                       input logic signed [ACC_W-1:0] b);
      logic signed [ACC_W:0] s;
      s = (ACC_W + 1)'(a) + (ACC_W + 1)'(b);
      if (s > ACC_MAX) begin
         s = ACC_MAX;
      end else if (s < ACC_MIN) begin
         s = ACC_MIN;
      end
      return s[ACC_W-1:0];
   endfunction

   // Row number modulo 3 by summing base-4 digits.
   function automatic logic [1:0] mod3_16(input logic [15:0] v);
      logic [4:0] s;
      logic [2:0] t;
      s = '0;
      for (int i = 0; i < 8; i++) begin
         s = s + 5'(v[2*i +: 2]);
      end
      t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
      if (t >= 3'd6) begin
         t = t - 3'd6;
      end else if (t >= 3'd3) begin
         t = t - 3'd3;
      end
      return t[1:0];
   endfunction

   // Difference of two values in 0..2, modulo 3.
   function automatic logic [1:0] sub3(input logic [1:0] a, input logic [1:0] b);
      logic [2:0] d;
      d = 3'(a) + 3'd3 - 3'(b);
      if (d >= 3'd3) begin
         d = d - 3'd3;
      end
      return d[1:0];
   endfunction

endpackage

`default_nettype wire

/* design/sedh_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module sedh_ram #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 1024
) (
   input wire logic clock,
   input wire logic write_en,
   input wire logic [$clog2(DEPTH)-1:0] write_addr,
   input wire logic [WIDTH-1:0] write_data,
   input wire logic read_en,
   input wire logic [$clog2(DEPTH)-1:0] read_addr,
   output logic [WIDTH-1:0] read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // One write and one registered read per cycle; the read word holds when idle.
   always_ff @(posedge clock) begin
      if (write_en) begin
         mem_ff[write_addr] <= write_data;
      end
      if (read_en) begin
         read_data <= mem_ff[read_addr];
      end
   end

endmodule

`default_nettype wire

/* design/sedh_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module sedh_front
   import sedh_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic invert_mode,
   input wire logic req_valid,
   input wire logic [PIX_W-1:0] req_pixel_value,
   output logic req_ready,
   output logic q_valid,
   output logic [PIX_W-1:0] q_pixel,
   input wire logic q_pop
);

   logic [PIX_W-1:0] slot_ff [2];
   logic wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic push;

   assign req_ready = (count_ff != 2'd2);
   assign push = req_valid && req_ready;
   assign q_valid = (count_ff != 2'd0);
   assign q_pixel = slot_ff[rd_ptr_ff];

   // Two-word queue; the complement for the CMY path is taken on entry.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= invert_mode ? ~req_pixel_value : req_pixel_value;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (q_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(push) - 2'(q_pop);
      end
   end

endmodule

`default_nettype wire

/* design/sedh_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module sedh_back
   import sedh_pkg::*;
#(
   parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
   input wire logic clock,
   input wire logic reset,
   input wire cfg_type cfg,
   input wire logic cfg_write,
   input wire logic q_valid,
   input wire logic [PIX_W-1:0] q_pixel,
   output logic q_pop,
   output logic rsp_valid,
   input wire logic rsp_ready,
   output logic [PIX_W-1:0] rsp_halftone_value,
   output logic rsp_end_of_image
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int PW = WW + 1;

   seq_state_type state_ff, state_in;
   logic [CW-1:0] clr_ff;
   logic [2:0] ld_ff;
   logic [1:0] fl_ff;
   logic [15:0] row_ff;
   logic [CW-1:0] col_ff;
   logic pending_ff, dirty_ff, need_clear_ff;

   // Window placement: width, parity and slot are fixed while loaded; the position steps per pixel.
   logic [WW-1:0] wpos_ff;
   logic [WW-1:0] win_w_ff;
   logic win_odd_ff;
   logic [1:0] win_slot_ff;

   // Current row at j..j+2, next and far rows at j-2..j+2.
   logic signed [ACC_W-1:0] c_ff [3];
   logic signed [ACC_W-1:0] n_ff [5];
   logic signed [ACC_W-1:0] f_ff [5];

   logic rsp_valid_ff;
   logic [PIX_W-1:0] halftone_ff;
   logic eoi_ff;

   // Effective image size.
   logic [WW-1:0] w_eff;
   logic [15:0] h_eff;
   logic [WW-1:0] col_c;
   logic [15:0] row_c;
   logic row_last, col_last, fire;

   always_comb begin
      if (cfg.image_width == 11'd0) begin
         w_eff = WW'(1);
      end else if (32'(cfg.image_width) > 32'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(cfg.image_width);
      end
      h_eff = (cfg.image_height == 16'd0) ? 16'd1 : cfg.image_height;
      col_c = (WW'(col_ff) >= w_eff) ? w_eff - WW'(1) : WW'(col_ff);
      row_c = (row_ff >= h_eff) ? h_eff - 16'd1 : row_ff;
   end

   assign col_last = (WW'(col_ff) == w_eff - WW'(1));
   assign row_last = (row_ff == h_eff - 16'd1);

   // Pixel decision and error spread.
   logic signed [ACC_W:0] v;
   logic high;
   logic signed [ACC_W-1:0] err;
   logic gate_n, gate_f;
   logic signed [ACC_W-1:0] c01, c02;
   logic signed [ACC_W-1:0] n_upd [5];
   logic signed [ACC_W-1:0] f_upd [5];

   always_comb begin
      v = $signed({3'b000, q_pixel, 8'h00}) + (ACC_W + 1)'(c_ff[0]);
      high = (v > THRESH_Q8);
      err = high ? ACC_W'(v - FULL_Q8) : ACC_W'(v);
      gate_n = ({1'b0, row_ff} + 17'd1) < {1'b0, h_eff};
      gate_f = ({1'b0, row_ff} + 17'd2) < {1'b0, h_eff};
      c01 = contrib(err, kernel_weight(cfg.kernel_select, 0, 3));
      c02 = contrib(err, kernel_weight(cfg.kernel_select, 0, 4));
      for (int k = 0; k < 5; k++) begin
         n_upd[k] = sat_add(n_ff[k],
                            gate_n ? contrib(err, kernel_weight(cfg.kernel_select, 1, k))
                                   : '0);
         f_upd[k] = sat_add(f_ff[k],
                            gate_f ? contrib(err, kernel_weight(cfg.kernel_select, 2, k))
                                   : '0);
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == CW'(MAX_WIDTH - 1)) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (ld_ff == 3'd6) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (pending_ff || (fire && col_last)) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (fl_ff == 2'd3) begin
               state_in = need_clear_ff ? ST_CLEAR : ST_LOAD;
            end
         end
      endcase
   end

   // Row store ports by role.
   logic we_r [3];
   logic signed [PW-1:0] wpos_r [3];
   logic [ACC_W-1:0] wdata_r [3];
   logic re;
   logic signed [PW-1:0] rpos;
   logic signed [PW-1:0] pos0;
   logic [ACC_W-1:0] rd_r [3];
   logic [ACC_W-1:0] ram_rdata [3];

   function automatic logic inside_row(input logic signed [PW-1:0] p,
                                       input logic [WW-1:0] w);
      return (p >= 0) && (p < $signed({1'b0, w}));
   endfunction

   assign pos0 = $signed({1'b0, wpos_ff});

   // Outputs of the sequencer.
   always_comb begin
      fire = 1'b0;
      re = 1'b0;
      rpos = pos0 + PW'(3);
      for (int r = 0; r < 3; r++) begin
         we_r[r] = 1'b0;
         wpos_r[r] = pos0;
         wdata_r[r] = '0;
      end
      unique case (state_ff)
         ST_CLEAR: begin
            for (int r = 0; r < 3; r++) begin
               we_r[r] = 1'b1;
               wpos_r[r] = $signed(PW'(clr_ff));
            end
         end
         ST_LOAD: begin
            re = (ld_ff != 3'd0);
            rpos = pos0 + $signed(PW'(ld_ff)) - PW'(3);
         end
         ST_RUN: begin
            // The word for j+3 is already on the read ports, so fetch j+4.
            fire = !pending_ff && q_valid && (!rsp_valid_ff || rsp_ready);
            re = fire;
            rpos = pos0 + PW'(4);
            we_r[ROLE_CUR] = fire;
            wpos_r[ROLE_CUR] = pos0;
            wpos_r[ROLE_NXT] = pos0 - PW'(2);
            wpos_r[ROLE_FAR] = pos0 - PW'(2);
            we_r[ROLE_NXT] = fire && inside_row(pos0 - PW'(2), win_w_ff);
            we_r[ROLE_FAR] = fire && inside_row(pos0 - PW'(2), win_w_ff);
            wdata_r[ROLE_NXT] = n_upd[0];
            wdata_r[ROLE_FAR] = f_upd[0];
         end
         ST_FLUSH: begin
            wpos_r[ROLE_CUR] = pos0 + $signed(PW'(fl_ff));
            wdata_r[ROLE_CUR] = c_ff[2'(fl_ff[0])];
            we_r[ROLE_CUR] = !fl_ff[1] && inside_row(pos0 + $signed(PW'(fl_ff)), win_w_ff);
            wpos_r[ROLE_NXT] = pos0 + $signed(PW'(fl_ff)) - PW'(2);
            wpos_r[ROLE_FAR] = pos0 + $signed(PW'(fl_ff)) - PW'(2);
            wdata_r[ROLE_NXT] = n_ff[3'(fl_ff)];
            wdata_r[ROLE_FAR] = f_ff[3'(fl_ff)];
            we_r[ROLE_NXT] = inside_row(pos0 + $signed(PW'(fl_ff)) - PW'(2), win_w_ff);
            we_r[ROLE_FAR] = we_r[ROLE_NXT];
         end
      endcase
   end

   // Map a scan position to a column address, mirrored on odd rows.
   function automatic logic [CW-1:0] phys(input logic signed [PW-1:0] p,
                                          input logic odd, input logic [WW-1:0] w,
                                          input logic raw);
      logic signed [PW-1:0] x;
      x = (odd && !raw) ? $signed({1'b0, w}) - PW'(1) - p : p;
      return x[CW-1:0];
   endfunction

   logic clearing;
   assign clearing = (state_ff == ST_CLEAR);

   // Three row stores; each one's role rotates with the row.
   for (genvar i = 0; i < 3; i++) begin : g_row
      logic [1:0] role;
      assign role = sub3(2'(i), win_slot_ff);
      assign rd_r[i] = ram_rdata[sub3(2'(i), 2'(3 - 3 * (i / 3)) - 2'd3) == 2'd0 ?
                                 2'(i) : 2'(i)];
      sedh_ram #(
         .WIDTH(ACC_W),
         .DEPTH(MAX_WIDTH)
      ) u_ram (
         .clock(clock),
         .write_en(we_r[role]),
         .write_addr(phys(wpos_r[role], win_odd_ff, win_w_ff, clearing)),
         .write_data(wdata_r[role]),
         .read_en(re),
         .read_addr(phys(rpos, win_odd_ff, win_w_ff, 1'b0)),
         .read_data(ram_rdata[i])
      );
   end

   // Read data by role.
   logic signed [ACC_W-1:0] rd_cur, rd_nxt, rd_far;
   always_comb begin
      rd_cur = $signed(rd_r[sub3(win_slot_ff, 2'd0)]);
      rd_nxt = $signed(rd_r[sub3(win_slot_ff, 2'd2)]);
      rd_far = $signed(rd_r[sub3(win_slot_ff, 2'd1)]);
   end

   // Window, counters and output word.
   always_ff @(posedge clock) begin
      if (state_ff == ST_LOAD && ld_ff >= 3'd2) begin
         n_ff[ld_ff - 3'd2] <= rd_nxt;
         f_ff[ld_ff - 3'd2] <= rd_far;
         if (ld_ff >= 3'd4) begin
            c_ff[2'(ld_ff - 3'd4)] <= rd_cur;
         end
      end
      if (fire) begin
         c_ff[0] <= sat_add(c_ff[1], c01);
         c_ff[1] <= sat_add(c_ff[2], c02);
         c_ff[2] <= rd_cur;
         for (int k = 0; k < 4; k++) begin
            n_ff[k] <= n_upd[k + 1];
            f_ff[k] <= f_upd[k + 1];
         end
         n_ff[4] <= rd_nxt;
         f_ff[4] <= rd_far;
         halftone_ff <= (high ^ cfg.invert_mode) ? 8'hFF : 8'h00;
         eoi_ff <= row_last && col_last;
      end
      if (state_ff == ST_LOAD && ld_ff == 3'd0) begin
         wpos_ff <= col_c;
         win_w_ff <= w_eff;
         win_odd_ff <= row_c[0];
         win_slot_ff <= mod3_16(row_c);
      end else if (fire) begin
         wpos_ff <= wpos_ff + WW'(1);
      end
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         ld_ff <= '0;
         fl_ff <= '0;
         row_ff <= '0;
         col_ff <= '0;
         pending_ff <= 1'b0;
         dirty_ff <= 1'b0;
         need_clear_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         win_slot_ff <= '0;
         win_odd_ff <= 1'b0;
         win_w_ff <= WW'(1);
         wpos_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff <= (state_ff == ST_CLEAR) ? clr_ff + CW'(1) : '0;
         ld_ff <= (state_ff == ST_LOAD && ld_ff != 3'd6) ? ld_ff + 3'd1 : 3'd0;
         fl_ff <= (state_ff == ST_FLUSH) ? fl_ff + 2'd1 : 2'd0;
         if (cfg_write) begin
            pending_ff <= 1'b1;
         end else if (state_ff == ST_LOAD && ld_ff == 3'd0) begin
            pending_ff <= 1'b0;
         end
         if (cfg_write && (row_ff != 16'd0 || col_ff != '0)) begin
            dirty_ff <= 1'b1;
         end else if (state_ff == ST_CLEAR) begin
            dirty_ff <= 1'b0;
         end
         if (state_ff == ST_CLEAR) begin
            need_clear_ff <= 1'b0;
         end else if (fire && row_last && col_last) begin
            need_clear_ff <= dirty_ff;
         end
         if (state_ff == ST_LOAD && ld_ff == 3'd0) begin
            row_ff <= row_c;
            col_ff <= CW'(col_c);
         end else if (fire) begin
            if (row_last && col_last) begin
               row_ff <= '0;
               col_ff <= '0;
            end else if (col_last) begin
               row_ff <= row_ff + 16'd1;
               col_ff <= '0;
            end else begin
               col_ff <= col_ff + CW'(1);
            end
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign q_pop = fire;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_halftone_value = halftone_ff;
   assign rsp_end_of_image = eoi_ff;

endmodule

`default_nettype wire

/* design/serpentine_error_diffusion_halftone.sv */
`timescale 1ns / 1ps
`default_nettype none
// A pixel's word passes through the two-word input queue and is registered on the output.
// Throughput: one pixel per cycle along a row while the output is not stalled; the error
// of each pixel reaches the next one through the registered window. Each row turn, and a
// register write, makes the block write the window back to the row stores and reload it
// from their registered read ports. Reset is synchronous; a clearing pass over all MAX_WIDTH
// columns then zeroes the row stores, and follows any plane during which a register was written.

module serpentine_error_diffusion_halftone
   import sedh_pkg::*;
#(
   parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_ready,
   input wire logic [PIX_W-1:0] req_pixel_value,
   output logic rsp_valid,
   input wire logic rsp_ready,
   output logic [PIX_W-1:0] rsp_halftone_value,
   output logic rsp_end_of_image,
   input wire logic csr_write_enable,
   input wire logic [1:0] csr_index,
   input wire logic [15:0] csr_write_data
);

   cfg_type cfg_ff;
   logic q_valid, q_pop;
   logic [PIX_W-1:0] q_pixel;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width <= 11'd512;
         cfg_ff.image_height <= 16'd512;
         cfg_ff.kernel_select <= KERNEL_FS;
         cfg_ff.invert_mode <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH: cfg_ff.image_width <= csr_write_data[10:0];
            REG_IMAGE_HEIGHT: cfg_ff.image_height <= csr_write_data;
            REG_KERNEL_SELECT: cfg_ff.kernel_select <= csr_write_data[1:0];
            REG_INVERT_MODE: cfg_ff.invert_mode <= csr_write_data[0];
         endcase
      end
   end

   sedh_front u_front (
      .clock(clock),
      .reset(reset),
      .invert_mode(cfg_ff.invert_mode),
      .req_valid(req_valid),
      .req_pixel_value(req_pixel_value),
      .req_ready(req_ready),
      .q_valid(q_valid),
      .q_pixel(q_pixel),
      .q_pop(q_pop)
   );

   sedh_back #(
      .MAX_WIDTH(MAX_WIDTH)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .cfg_write(csr_write_enable),
      .q_valid(q_valid),
      .q_pixel(q_pixel),
      .q_pop(q_pop),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_halftone_value(rsp_halftone_value),
      .rsp_end_of_image(rsp_end_of_image)
   );

endmodule

`default_nettype wire

/* bench/serpentine_halftone_checker.sv */
`timescale 1ns / 1ps

module serpentine_halftone_checker
   import sedh_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic [PIX_W-1:0] req_pixel_value,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic [PIX_W-1:0] rsp_halftone_value,
   input wire logic rsp_end_of_image,
   input wire logic csr_write_enable,
   input wire logic [1:0] csr_index,
   input wire logic [15:0] csr_write_data,
   output int failures,
   output int pending
);

   localparam int ROW_SLOTS = 1024;
   localparam int LEVEL_THRESHOLD = 32512;
   localparam int LEVEL_FULL = 65280;
   localparam int ERR_MAX = 131071;
   localparam int ERR_MIN = -131072;

   typedef struct {
      logic [PIX_W-1:0] level;
      logic last_pixel;
   } halftone_word_type;

   // Mirror of the block state: three rolling error rows, scan position and registers.
   int diffusion_rows [3 * ROW_SLOTS];
   int unsigned scan_row;
   int unsigned scan_col;
   logic [10:0] plane_width;
   logic [15:0] plane_height;
   logic [1:0] kernel_code;
   logic invert_on;
   halftone_word_type expected_words [$];

   // Q.12 weight of one tap; dx is along the scan direction.
   function automatic int tap_weight(input logic [1:0] k, input int dy, input int dx);
      int wt;
      wt = 0;
      case (k)
         KERNEL_JJN: begin
            case (dy)
               0: wt = (dx == 1) ? 597 : (dx == 2) ? 427 : 0;
               1: wt = (dx == 0) ? 597 : (dx == 1 || dx == -1) ? 427 : 256;
               default: wt = (dx == 0) ? 427 : (dx == 1 || dx == -1) ? 256 : 85;
            endcase
         end
         KERNEL_STUCKI: begin
            case (dy)
               0: wt = (dx == 1) ? 780 : (dx == 2) ? 390 : 0;
               1: wt = (dx == 0) ? 780 : (dx == 1 || dx == -1) ? 390 : 195;
               default: wt = (dx == 0) ? 390 : (dx == 1 || dx == -1) ? 195 : 98;
            endcase
         end
         default: begin
            if (dy == 0 && dx == 1) wt = 1792;
            else if (dy == 1 && dx == -1) wt = 768;
            else if (dy == 1 && dx == 0) wt = 1280;
            else if (dy == 1 && dx == 1) wt = 256;
         end
      endcase
      return wt;
   endfunction

   // Error times weight, rounded from Q.20 to Q.8 with halves going up.
   function automatic int weighted_error(input int e, input int wt);
      longint q;
      q = longint'(e) * longint'(wt) + 2048;
      return int'(q >>> 12);
   endfunction

   task automatic clear_rows();
      foreach (diffusion_rows[i]) diffusion_rows[i] = 0;
   endtask

   // Quantize one pixel, spread its error and queue the word it must produce.
   task automatic halftone_pixel(input logic [PIX_W-1:0] pixel_in);
      int w;
      int h;
      int pix;
      int x;
      int v;
      int err_q8;
      int wt;
      int tx;
      int ty;
      int idx;
      int sum;
      bit odd_row;
      bit high;
      bit last;
      halftone_word_type word;
      w = plane_width;
      if (w < 1) w = 1;
      if (w > ROW_SLOTS) w = ROW_SLOTS;
      h = plane_height;
      if (h < 1) h = 1;
      // A shrinking register write pins the scan to the new last column or row.
      if (scan_col >= w) scan_col = w - 1;
      if (scan_row >= h) scan_row = h - 1;
      pix = invert_on ? 255 - int'(pixel_in) : int'(pixel_in);
      odd_row = scan_row[0];
      x = odd_row ? w - 1 - int'(scan_col) : int'(scan_col);
      idx = (scan_row % 3) * ROW_SLOTS + x;
      v = pix * 256 + diffusion_rows[idx];
      diffusion_rows[idx] = 0;
      high = v > LEVEL_THRESHOLD;
      err_q8 = high ? v - LEVEL_FULL : v;
      for (int dy = 0; dy < 3; dy++) begin
         for (int dx = -2; dx <= 2; dx++) begin
            wt = tap_weight(kernel_code, dy, dx);
            tx = odd_row ? x - dx : x + dx;
            ty = int'(scan_row) + dy;
            if (wt != 0 && ty < h && tx >= 0 && tx < w) begin
               idx = (ty % 3) * ROW_SLOTS + tx;
               sum = diffusion_rows[idx] + weighted_error(err_q8, wt);
               if (sum > ERR_MAX) sum = ERR_MAX;
               if (sum < ERR_MIN) sum = ERR_MIN;
               diffusion_rows[idx] = sum;
            end
         end
      end
      high = high ^ invert_on;
      last = (scan_row == h - 1) && (scan_col == w - 1);
      word.level = high ? 8'd255 : 8'd0;
      word.last_pixel = last;
      expected_words.push_back(word);
      // Advance the serpentine scan; the end of the plane wipes all error rows.
      if (last) begin
         scan_row = 0;
         scan_col = 0;
         clear_rows();
      end else if (scan_col == w - 1) begin
         scan_col = 0;
         scan_row++;
      end else begin
         scan_col++;
      end
   endtask

   // Track the channels at every edge: predict accepted pixels, apply register writes, check words.
   always @(posedge clock) begin
      halftone_word_type want;
      if (reset) begin
         clear_rows();
         scan_row = 0;
         scan_col = 0;
         plane_width = 11'd512;
         plane_height = 16'd512;
         kernel_code = KERNEL_FS;
         invert_on = 1'b0;
         expected_words.delete();
         failures <= 0;
      end else begin
         if (req_valid && req_ready) begin
            halftone_pixel(req_pixel_value);
         end
         if (csr_write_enable) begin
            case (csr_index)
               REG_IMAGE_WIDTH: plane_width = csr_write_data[10:0];
               REG_IMAGE_HEIGHT: plane_height = csr_write_data;
               REG_KERNEL_SELECT: kernel_code = csr_write_data[1:0];
               default: invert_on = csr_write_data[0];
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected word: halftone %0d end %0d", $time,
                        rsp_halftone_value, rsp_end_of_image);
               failures <= failures + 1;
            end else begin
               want = expected_words.pop_front();
               if (rsp_halftone_value !== want.level) begin
                  $display("%0t: halftone_value expected %0d actual %0d", $time,
                           want.level, rsp_halftone_value);
                  failures <= failures + 1;
               end else if (rsp_end_of_image !== want.last_pixel) begin
                  $display("%0t: end_of_image expected %0d actual %0d", $time,
                           want.last_pixel, rsp_end_of_image);
                  failures <= failures + 1;
               end
            end
         end
      end
      pending <= expected_words.size();
   end

endmodule

/* bench/tb_serpentine_error_diffusion_halftone.sv */
`timescale 1ns / 1ps

module tb_serpentine_error_diffusion_halftone;
   import sedh_pkg::*;

   localparam int STALL_LIMIT = 6000;
   localparam int SETTLE_CYCLES = 24;
   localparam int HOLD_CYCLES = 200;
   localparam int PIXEL_TARGET = 1200;
   localparam int WIDE_ROW = 1024;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [PIX_W-1:0] req_pixel_value;
   logic rsp_valid;
   logic rsp_ready;
   logic [PIX_W-1:0] rsp_halftone_value;
   logic rsp_end_of_image;
   logic csr_write_enable;
   logic [1:0] csr_index;
   logic [15:0] csr_write_data;
   int failures;
   int pending;

   int sender_idle_pct;
   int receiver_stall_pct;
   int hold_orders;
   int hold_taken;
   int hold_left;
   int quiet_cycles;
   int pixels_sent;

   serpentine_error_diffusion_halftone dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_pixel_value(req_pixel_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_halftone_value(rsp_halftone_value),
      .rsp_end_of_image(rsp_end_of_image),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   serpentine_halftone_checker halftone_check (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_pixel_value(req_pixel_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_halftone_value(rsp_halftone_value),
      .rsp_end_of_image(rsp_end_of_image),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .failures(failures),
      .pending(pending)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Word receiver: random stalls, plus a long hold-off whenever one is ordered.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left = hold_left - 1;
      end else if (hold_orders != hold_taken) begin
         hold_taken = hold_orders;
         hold_left = HOLD_CYCLES - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   // Watchdog on cycles in which neither channel moves a word.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one pixel, after a random gap when the sender is idling.
   task automatic push_pixel(input logic [PIX_W-1:0] value);
      int gap;
      gap = 0;
      while ($urandom_range(0, 99) < sender_idle_pct && gap < 200) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel_value <= value;
      do @(posedge clock); while (!req_ready);
      pixels_sent++;
   endtask

   // Stop offering and wait until every expected word has come out.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all four registers on consecutive edges.
   task automatic set_config(input logic [15:0] w, input logic [15:0] h,
                             input logic [1:0] k, input logic inv);
      csr_write_enable <= 1'b1;
      csr_index <= REG_IMAGE_WIDTH;
      csr_write_data <= w;
      @(posedge clock);
      csr_index <= REG_IMAGE_HEIGHT;
      csr_write_data <= h;
      @(posedge clock);
      csr_index <= REG_KERNEL_SELECT;
      csr_write_data <= {14'd0, k};
      @(posedge clock);
      csr_index <= REG_INVERT_MODE;
      csr_write_data <= {15'd0, inv};
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [PIX_W-1:0] random_pixel();
      case ($urandom_range(0, 9))
         0: return 8'd0;
         1: return 8'd255;
         2: return 8'(127 + $urandom_range(0, 1));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic run_plane(input int w, input int h, input logic [1:0] k, input logic inv);
      set_config(16'(w), 16'(h), k, inv);
      for (int i = 0; i < w * h; i++) push_pixel(random_pixel());
      drain();
   endtask

   initial begin
      int plane;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_pixel_value <= '0;
      csr_write_enable <= 1'b0;
      csr_index <= REG_IMAGE_WIDTH;
      csr_write_data <= '0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      hold_orders = 0;
      hold_taken = 0;
      hold_left = 0;
      pixels_sent = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: Floyd-Steinberg over extremes and the threshold edge.
      set_config(16'd4, 16'd3, KERNEL_FS, 1'b0);
      push_pixel(8'd0);
      push_pixel(8'd255);
      push_pixel(8'd127);
      push_pixel(8'd128);
      push_pixel(8'd255);
      push_pixel(8'd255);
      push_pixel(8'd0);
      push_pixel(8'd0);
      push_pixel(8'd170);
      push_pixel(8'd85);
      push_pixel(8'd1);
      push_pixel(8'd254);
      drain();
      // Directed: the two wide kernels, inverted and not.
      set_config(16'd3, 16'd2, KERNEL_JJN, 1'b1);
      for (int i = 0; i < 6; i++) push_pixel((i % 2 == 0) ? 8'd0 : 8'd255);
      drain();
      set_config(16'd2, 16'd1, KERNEL_STUCKI, 1'b0);
      push_pixel(8'd200);
      push_pixel(8'd60);
      drain();
      // Zero width, zero height and the spare kernel code give a one-pixel plane.
      set_config(16'd0, 16'd0, 2'd3, 1'b1);
      push_pixel(8'd128);
      drain();
      // Oversized width and the tallest plane, then a shrink in mid-plane.
      set_config(16'd2047, 16'd65535, KERNEL_STUCKI, 1'b0);
      push_pixel(8'd255);
      push_pixel(8'd100);
      push_pixel(8'd30);
      drain();
      set_config(16'd2, 16'd1, KERNEL_FS, 1'b0);
      push_pixel(8'd140);
      drain();

      // Backpressure: the receiver holds off while the sender keeps offering.
      hold_orders = hold_orders + 1;
      run_plane(8, 6, KERNEL_JJN, 1'b0);

      // Random planes, cycling through the idling patterns; the wide row comes last.
      plane = 0;
      while (pixels_sent < PIXEL_TARGET - WIDE_ROW || plane < 4) begin
         case (plane % 5)
            1: begin
               sender_idle_pct = 86;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 86;
            end
            3: begin
               sender_idle_pct = 35;
               receiver_stall_pct = 35;
            end
            default: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 0;
            end
         endcase
         run_plane(($urandom_range(0, 15) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12),
                   $urandom_range(1, 6), 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
         plane++;
      end

      // Widest legal row, once, as a single-row plane.
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      run_plane(WIDE_ROW, 1, KERNEL_STUCKI, 1'b1);

      if (failures == 0 && pending == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

/* files.f */
design/sedh_pkg.sv
design/sedh_ram.sv
design/sedh_front.sv
design/sedh_back.sv
design/serpentine_error_diffusion_halftone.sv
bench/serpentine_halftone_checker.sv
bench/tb_serpentine_error_diffusion_halftone.sv
